// ===== sv/qoi_dec_pkg.sv =====
// qoi_dec_pkg: types, opcode codes and the index hash for the qoi pixel stream decoder
// used by qoi_dec_ctrl, qoi_dec_dpath and qoi_pixel_stream_decoder; no dependencies
`default_nettype none

package qoi_dec_pkg;

  localparam int unsigned BUDGET_W  = 25;
  localparam int unsigned IDX_DEPTH = 64;
  localparam int unsigned IDX_AW    = $clog2(IDX_DEPTH);
  localparam int unsigned RUN_W     = 6;

  // opcode bytes and two-bit tags
  localparam logic [7:0] OPC_RGBA  = 8'hFF;
  localparam logic [7:0] OPC_RGB   = 8'hFE;
  localparam logic [1:0] TAG_INDEX = 2'b00;
  localparam logic [1:0] TAG_DIFF  = 2'b01;
  localparam logic [1:0] TAG_LUMA  = 2'b10;
  localparam logic [1:0] TAG_RUN   = 2'b11;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } pixel_t;

  localparam pixel_t START_PIXEL = '{r: 8'd0, g: 8'd0, b: 8'd0, a: 8'd255};

  // decoder phase, which doubles as the controller state
  typedef enum logic [3:0] {
    S_OPCODE,
    S_RGBA_R,
    S_RGBA_G,
    S_RGBA_B,
    S_RGBA_A,
    S_RGB_R,
    S_RGB_G,
    S_RGB_B,
    S_LUMA2,
    S_INDEX,
    S_RUN
  } state_e;

  // channel update applied to the previous pixel
  typedef enum logic [2:0] {
    OP_NONE,
    OP_SET_R,
    OP_SET_G,
    OP_SET_B,
    OP_SET_A,
    OP_DIFF,
    OP_LUMA1,
    OP_LUMA2
  } op_e;

  // source of an emitted pixel
  typedef enum logic [1:0] {
    SRC_CALC,
    SRC_INDEX,
    SRC_PREV
  } src_e;

  typedef enum logic [2:0] {
    CLS_RGBA,
    CLS_RGB,
    CLS_INDEX,
    CLS_DIFF,
    CLS_LUMA,
    CLS_RUN
  } cls_e;

  typedef struct packed {
    logic restart;
    op_e  op;
    logic emit;
    src_e src;
    logic last;
    logic refuse;
    logic idx_read;
    logic load_run;
    logic run_dec;
  } cmd_t;

  typedef struct packed {
    logic left_zero;
    logic left_one;
    logic run_one;
    logic out_free;
    cls_e cls;
  } status_t;

  // index slot (3r + 5g + 7b + 11a) mod 64
  function automatic logic [IDX_AW-1:0] hash_f(pixel_t p);
    logic [IDX_AW-1:0] r3;
    logic [IDX_AW-1:0] g5;
    logic [IDX_AW-1:0] b7;
    logic [IDX_AW-1:0] a11;
    r3  = IDX_AW'(p.r[IDX_AW-1:0] * IDX_AW'(3));
    g5  = IDX_AW'(p.g[IDX_AW-1:0] * IDX_AW'(5));
    b7  = IDX_AW'(p.b[IDX_AW-1:0] * IDX_AW'(7));
    a11 = IDX_AW'(p.a[IDX_AW-1:0] * IDX_AW'(11));
    return IDX_AW'(r3 + g5 + b7 + a11);
  endfunction

endpackage

`default_nettype wire

// ===== sv/qoi_pixel_stream_decoder.sv =====
// qoi_pixel_stream_decoder: top level of the byte-serial qoi pixel stream decoder
// depends on qoi_dec_pkg, qoi_dec_ctrl and qoi_dec_dpath
//
// usage
//   in channel (in_valid_i/in_ready_o/in_byte_i) takes the qoi data bytes that follow the
//   header, one item per handshake. out channel (out_valid_o/out_ready_i) returns decoded
//   rgba pixels; last_of_run_o marks the final result caused by an input byte, refused_o
//   marks a byte turned away because the pixel budget is used up (pixel fields are zero).
//   cfg channel (cfg_valid_i/cfg_ready_o/cfg_pixel_budget_i) loads width times height and
//   restarts decoding: phase, previous pixel and colour index go back to their start values.
//   cfg_ready_o is always high; write it only while the block is idle.
// timing
//   rgb, rgba, diff, luma and refused bytes: one byte a cycle while the result register is
//   free, result registered and shown in the cycle after the item that completes the pixel.
//   index bytes: intake held for the registered read of the colour index memory. run bytes:
//   one pixel a cycle out of the run counter while the receiver keeps up, intake held meanwhile.
//   a single result register sits between the sides: intake needs that register free or
//   being taken in the same cycle, so a waiting result that the receiver holds off stops
//   every byte, whether it completes a pixel or not.
// reset
//   phase expects an opcode, previous pixel is (0,0,0,255), colour index reads as zero and
//   the budget is zero, so every byte is refused until the budget is configured.
//   a stalled receiver simply holds the result register; nothing is dropped.
`default_nettype none

module qoi_pixel_stream_decoder import qoi_dec_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [BUDGET_W-1:0] cfg_pixel_budget_i,
  // byte intake
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          in_byte_i,
  // pixel results
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [7:0]               red_o,
  output logic [7:0]               green_o,
  output logic [7:0]               blue_o,
  output logic [7:0]               alpha_o,
  output logic                     last_of_run_o,
  output logic                     refused_o
);

  cmd_t    cmd;
  status_t status;

  // register writes are taken at any time; the restart takes priority over intake
  assign cfg_ready_o = 1'b1;

  // phase sequencing, run and index fetch control
  qoi_dec_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // pixel arithmetic, colour index, counters and result register
  qoi_dec_dpath u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .cfg_pixel_budget_i (cfg_pixel_budget_i),
    .in_byte_i          (in_byte_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .red_o              (red_o),
    .green_o            (green_o),
    .blue_o             (blue_o),
    .alpha_o            (alpha_o),
    .last_of_run_o      (last_of_run_o),
    .refused_o          (refused_o)
  );

endmodule

`default_nettype wire

// ===== sv/qoi_dec_ctrl.sv =====
// qoi_dec_ctrl: phase state machine of the qoi pixel stream decoder
// depends on qoi_dec_pkg; drives qoi_dec_dpath through cmd_t and reads status_t
`default_nettype none

module qoi_dec_ctrl import qoi_dec_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    cfg_valid_i,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;
  logic   accepting;
  logic   acc;
  logic   run_last;

  // the index fetch and run states hold off intake
  assign accepting  = (state_q != S_INDEX) && (state_q != S_RUN);
  assign in_ready_o = accepting && status_i.out_free && !cfg_valid_i;
  assign acc        = in_valid_i && in_ready_o;
  assign run_last   = status_i.run_one || status_i.left_one;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_OPCODE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    if (cfg_valid_i) begin
      cmd_o.restart = 1'b1;
      state_d       = S_OPCODE;
    end else begin
      case (state_q)
        S_INDEX: begin
          if (status_i.out_free) begin
            cmd_o.emit = 1'b1;
            cmd_o.src  = SRC_INDEX;
            cmd_o.last = 1'b1;
            state_d    = S_OPCODE;
          end
        end
        S_RUN: begin
          if (status_i.out_free) begin
            cmd_o.emit    = 1'b1;
            cmd_o.src     = SRC_PREV;
            cmd_o.run_dec = 1'b1;
            cmd_o.last    = run_last;
            if (run_last) begin
              state_d = S_OPCODE;
            end
          end
        end
        default: begin
          if (acc && status_i.left_zero) begin
            cmd_o.refuse = 1'b1;
          end else if (acc) begin
            case (state_q)
              S_RGBA_R: begin
                cmd_o.op = OP_SET_R;
                state_d  = S_RGBA_G;
              end
              S_RGBA_G: begin
                cmd_o.op = OP_SET_G;
                state_d  = S_RGBA_B;
              end
              S_RGBA_B: begin
                cmd_o.op = OP_SET_B;
                state_d  = S_RGBA_A;
              end
              S_RGBA_A: begin
                cmd_o.op   = OP_SET_A;
                cmd_o.emit = 1'b1;
                cmd_o.src  = SRC_CALC;
                cmd_o.last = 1'b1;
                state_d    = S_OPCODE;
              end
              S_RGB_R: begin
                cmd_o.op = OP_SET_R;
                state_d  = S_RGB_G;
              end
              S_RGB_G: begin
                cmd_o.op = OP_SET_G;
                state_d  = S_RGB_B;
              end
              S_RGB_B: begin
                cmd_o.op   = OP_SET_B;
                cmd_o.emit = 1'b1;
                cmd_o.src  = SRC_CALC;
                cmd_o.last = 1'b1;
                state_d    = S_OPCODE;
              end
              S_LUMA2: begin
                cmd_o.op   = OP_LUMA2;
                cmd_o.emit = 1'b1;
                cmd_o.src  = SRC_CALC;
                cmd_o.last = 1'b1;
                state_d    = S_OPCODE;
              end
              default: begin
                // expecting an opcode
                case (status_i.cls)
                  CLS_RGBA:  state_d = S_RGBA_R;
                  CLS_RGB:   state_d = S_RGB_R;
                  CLS_INDEX: begin
                    cmd_o.idx_read = 1'b1;
                    state_d        = S_INDEX;
                  end
                  CLS_DIFF: begin
                    cmd_o.op   = OP_DIFF;
                    cmd_o.emit = 1'b1;
                    cmd_o.src  = SRC_CALC;
                    cmd_o.last = 1'b1;
                    state_d    = S_OPCODE;
                  end
                  CLS_LUMA: begin
                    cmd_o.op = OP_LUMA1;
                    state_d  = S_LUMA2;
                  end
                  CLS_RUN: begin
                    cmd_o.load_run = 1'b1;
                    state_d        = S_RUN;
                  end
                  default: state_d = S_OPCODE;
                endcase
              end
            endcase
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/qoi_dec_dpath.sv =====
// qoi_dec_dpath: previous pixel, colour index memory, budget and run counters, result register
// depends on qoi_dec_pkg; commanded by qoi_dec_ctrl
`default_nettype none

module qoi_dec_dpath import qoi_dec_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cmd_t                cmd_i,
  output status_t                  status_o,
  input  wire logic [BUDGET_W-1:0] cfg_pixel_budget_i,
  input  wire logic [7:0]          in_byte_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [7:0]               red_o,
  output logic [7:0]               green_o,
  output logic [7:0]               blue_o,
  output logic [7:0]               alpha_o,
  output logic                     last_of_run_o,
  output logic                     refused_o
);

  pixel_t              prev_q, prev_d;
  pixel_t              calc_pix;
  pixel_t              idx_pix;
  pixel_t              emit_pix;
  logic [7:0]          luma_dg;
  logic [IDX_AW-1:0]   wr_slot;
  logic [IDX_AW-1:0]   rd_slot;
  logic [BUDGET_W-1:0] left_q, left_d;
  logic [RUN_W-1:0]    run_q, run_d;

  // colour index: memory plus one valid bit per slot, invalid reads as zero
  pixel_t              mem_q [IDX_DEPTH];
  logic [IDX_DEPTH-1:0] vld_q;
  pixel_t              rdata_q;
  logic                rvld_q;

  // result register
  logic                out_valid_q;
  pixel_t              out_pix_q;
  logic                out_last_q;
  logic                out_ref_q;

  assign luma_dg = {2'b00, in_byte_i[5:0]} - 8'd32;
  assign rd_slot = in_byte_i[IDX_AW-1:0];

  always_comb begin
    calc_pix = prev_q;
    case (cmd_i.op)
      OP_SET_R: calc_pix.r = in_byte_i;
      OP_SET_G: calc_pix.g = in_byte_i;
      OP_SET_B: calc_pix.b = in_byte_i;
      OP_SET_A: calc_pix.a = in_byte_i;
      OP_DIFF: begin
        calc_pix.r = prev_q.r + {6'd0, in_byte_i[5:4]} - 8'd2;
        calc_pix.g = prev_q.g + {6'd0, in_byte_i[3:2]} - 8'd2;
        calc_pix.b = prev_q.b + {6'd0, in_byte_i[1:0]} - 8'd2;
      end
      OP_LUMA1: begin
        calc_pix.r = prev_q.r + luma_dg;
        calc_pix.g = prev_q.g + luma_dg;
        calc_pix.b = prev_q.b + luma_dg;
      end
      OP_LUMA2: begin
        calc_pix.r = prev_q.r + {4'd0, in_byte_i[7:4]} - 8'd8;
        calc_pix.b = prev_q.b + {4'd0, in_byte_i[3:0]} - 8'd8;
      end
      default: calc_pix = prev_q;
    endcase
  end

  assign idx_pix = rvld_q ? rdata_q : '0;

  always_comb begin
    case (cmd_i.src)
      SRC_INDEX: emit_pix = idx_pix;
      SRC_PREV:  emit_pix = prev_q;
      default:   emit_pix = calc_pix;
    endcase
  end

  assign wr_slot = hash_f(emit_pix);

  always_comb begin
    prev_d = prev_q;
    left_d = left_q;
    run_d  = run_q;
    if (cmd_i.restart) begin
      prev_d = START_PIXEL;
      left_d = cfg_pixel_budget_i;
    end else begin
      if (cmd_i.emit) begin
        prev_d = emit_pix;
        left_d = left_q - BUDGET_W'(1);
      end else if (cmd_i.op != OP_NONE) begin
        prev_d = calc_pix;
      end
      if (cmd_i.load_run) begin
        run_d = in_byte_i[RUN_W-1:0] + RUN_W'(1);
      end else if (cmd_i.run_dec) begin
        run_d = run_q - RUN_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= START_PIXEL;
      left_q      <= '0;
      run_q       <= '0;
      vld_q       <= '0;
      rvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      prev_q <= prev_d;
      left_q <= left_d;
      run_q  <= run_d;
      if (cmd_i.restart) begin
        vld_q <= '0;
      end else if (cmd_i.emit) begin
        vld_q[wr_slot] <= 1'b1;
      end
      if (cmd_i.idx_read) begin
        rvld_q <= vld_q[rd_slot];
      end
      if (cmd_i.emit || cmd_i.refuse) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // index memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      mem_q[wr_slot] <= emit_pix;
    end
    if (cmd_i.idx_read) begin
      rdata_q <= mem_q[rd_slot];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_pix_q  <= emit_pix;
      out_last_q <= cmd_i.last;
      out_ref_q  <= 1'b0;
    end else if (cmd_i.refuse) begin
      out_pix_q  <= '0;
      out_last_q <= 1'b1;
      out_ref_q  <= 1'b1;
    end
  end

  always_comb begin
    status_o.left_zero = (left_q == '0);
    status_o.left_one  = (left_q == BUDGET_W'(1));
    status_o.run_one   = (run_q == RUN_W'(1));
    status_o.out_free  = !out_valid_q || out_ready_i;
    if (in_byte_i == OPC_RGBA) begin
      status_o.cls = CLS_RGBA;
    end else if (in_byte_i == OPC_RGB) begin
      status_o.cls = CLS_RGB;
    end else begin
      case (in_byte_i[7:6])
        TAG_INDEX: status_o.cls = CLS_INDEX;
        TAG_DIFF:  status_o.cls = CLS_DIFF;
        TAG_LUMA:  status_o.cls = CLS_LUMA;
        TAG_RUN:   status_o.cls = CLS_RUN;
        default:   status_o.cls = CLS_RUN;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign red_o         = out_pix_q.r;
  assign green_o       = out_pix_q.g;
  assign blue_o        = out_pix_q.b;
  assign alpha_o       = out_pix_q.a;
  assign last_of_run_o = out_last_q;
  assign refused_o     = out_ref_q;

  // a pixel is emitted only while budget remains
  a_emit_has_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !status_o.left_zero)
    else $error("pixel emitted with no budget left");

  // every emitted pixel takes exactly one from the budget
  a_emit_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> left_q == $past(left_q) - BUDGET_W'(1))
    else $error("budget count out of step with emitted pixels");

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit || cmd_i.refuse) |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  // a refused item is always flagged last and carries a zero pixel
  a_refused_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ref_q) |-> (out_last_q && out_pix_q == '0))
    else $error("malformed refused result");

endmodule

`default_nettype wire
